FILE: rtl/pdu_pkg.sv
// Package for the percent decoder with UTF-8 check: status codes, the item
// record carried between the stages, character constants and the hex helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdu_pkg;

    // Final status codes, reported with the last byte of a string
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_PERCENT = 3'd1,
        ST_CONTROL     = 3'd2,
        ST_BAD_UTF8    = 3'd3,
        ST_TOO_LONG    = 3'd4
    } t_status;

    // One item as it moves through both queues
    typedef struct packed {
        logic       valid;   // data carries a decoded byte
        logic [7:0] data;    // decoded byte, zero when not valid
        logic       last;    // closes the string
        t_status    status;  // front status in the middle queue, final at the output
    } t_item;

    // Configuration register indexes
    localparam logic CFG_PLUS_SPACE = 1'b0;
    localparam logic CFG_MAX_LEN    = 1'b1;

    localparam logic [15:0] MAX_LEN_RESET = 16'd16384;

    // Queue depth, shared by both queues
    localparam int PDU_FIFO_DEPTH = 2;
    localparam int PDU_PTR_W      = (PDU_FIFO_DEPTH > 1) ? $clog2(PDU_FIFO_DEPTH) : 1;
    localparam int PDU_CNT_W      = $clog2(PDU_FIFO_DEPTH + 1);

    // Encoded length counter saturates here
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    // Characters
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CTRL_LIMIT   = 8'h20;
    localparam logic [7:0] CHAR_DEL     = 8'h7F;

    // UTF-8 lead byte ranges and code point limits
    localparam logic [7:0]  UTF8_ASCII_MAX = 8'h7F;
    localparam logic [7:0]  UTF8_LEAD2_MIN = 8'hC2;
    localparam logic [7:0]  UTF8_LEAD2_MAX = 8'hDF;
    localparam logic [7:0]  UTF8_LEAD3_MIN = 8'hE0;
    localparam logic [7:0]  UTF8_LEAD3_MAX = 8'hEF;
    localparam logic [7:0]  UTF8_LEAD4_MIN = 8'hF0;
    localparam logic [7:0]  UTF8_LEAD4_MAX = 8'hF4;
    localparam logic [20:0] CP_MIN_3BYTE   = 21'h000800;
    localparam logic [20:0] CP_MIN_4BYTE   = 21'h010000;
    localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] CP_MAX         = 21'h10FFFF;

    // Hex digit value; bit 4 set when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pdu_fifo.sv
// Small first-in first-out queue of t_item records, depth from pdu_pkg.
// Depends on pdu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdu_fifo
    import pdu_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_item i_wr_data,
    output logic  o_full,
    input  wire   i_pop,
    output t_item o_rd_data,
    output logic  o_empty
);

    t_item                r_mem [PDU_FIFO_DEPTH];
    logic [PDU_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PDU_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PDU_CNT_W-1:0] r_count, n_count;
    logic                 wr_fire;
    logic                 rd_fire;

    assign o_full    = (r_count == PDU_CNT_W'(PDU_FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_fire   = i_push && !o_full;
    assign rd_fire   = i_pop && !o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_fire) begin
            n_wr_ptr = (r_wr_ptr == PDU_PTR_W'(PDU_FIFO_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + 1'b1;
        end
        if (rd_fire) begin
            n_rd_ptr = (r_rd_ptr == PDU_PTR_W'(PDU_FIFO_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + 1'b1;
        end
        if (wr_fire && !rd_fire) begin
            n_count = r_count + 1'b1;
        end else if (rd_fire && !wr_fire) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pdu_front.sv
// Front stage: configuration registers, length count, percent and plus
// decoding, control byte check. Produces one t_item per accepted byte.
// Depends on pdu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdu_front
    import pdu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    input  wire         i_fire,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_in_last,
    output t_item       o_item
);

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_HIGH,
        ESC_LOW
    } t_esc_phase;

    logic        r_plus_space;
    logic [15:0] r_max_len;
    t_esc_phase  r_phase, n_phase;
    logic [3:0]  r_nibble, n_nibble;
    logic [16:0] r_count, n_count;
    t_status     r_err, n_err;

    logic [4:0]  hex;
    logic        have;
    logic [7:0]  value;
    logic        too_long;
    logic        emit;

    // Decode one byte against the running string state
    always_comb begin
        n_count = r_count;
        if (r_count != COUNT_MAX) begin
            n_count = r_count + 17'd1;
        end
        too_long = (n_count > {1'b0, r_max_len});
        hex      = hex_value(i_in_byte);
        n_phase  = r_phase;
        n_nibble = r_nibble;
        n_err    = r_err;
        have     = 1'b0;
        value    = 8'h00;

        case (r_phase)
            ESC_IDLE: begin
                if (i_in_byte == CHAR_PERCENT) begin
                    n_phase = ESC_HIGH;
                end else begin
                    value = (i_in_byte == CHAR_PLUS && r_plus_space) ? CHAR_SPACE
                                                                     : i_in_byte;
                    have  = 1'b1;
                end
            end
            ESC_HIGH: begin
                if (hex[4] && r_err == ST_OK) begin
                    n_err = ST_BAD_PERCENT;
                end
                n_nibble = hex[3:0];
                n_phase  = ESC_LOW;
            end
            ESC_LOW: begin
                if (hex[4]) begin
                    if (r_err == ST_OK) begin
                        n_err = ST_BAD_PERCENT;
                    end
                end else begin
                    value = {r_nibble, hex[3:0]};
                    have  = 1'b1;
                end
                n_phase = ESC_IDLE;
            end
            default: begin
                n_phase = ESC_IDLE;
            end
        endcase

        // Control bytes are dropped and flagged
        if (have && (value < CTRL_LIMIT || value == CHAR_DEL)) begin
            if (n_err == ST_OK) begin
                n_err = ST_CONTROL;
            end
            have = 1'b0;
        end

        emit = have && (n_err == ST_OK) && !too_long;

        // Escape left open at the end of the string
        if (i_in_last && n_phase != ESC_IDLE && n_err == ST_OK) begin
            n_err = ST_BAD_PERCENT;
        end

        o_item.valid  = emit;
        o_item.data   = emit ? value : 8'h00;
        o_item.last   = i_in_last;
        o_item.status = !i_in_last ? ST_OK : (too_long ? ST_TOO_LONG : n_err);
    end

    // Configuration and string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_space <= 1'b1;
            r_max_len    <= MAX_LEN_RESET;
            r_phase      <= ESC_IDLE;
            r_nibble     <= 4'h0;
            r_count      <= 17'd0;
            r_err        <= ST_OK;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PLUS_SPACE: r_plus_space <= i_cfg_data[0];
                    CFG_MAX_LEN:    r_max_len    <= i_cfg_data;
                    default:        r_max_len    <= r_max_len;
                endcase
            end
            if (i_fire) begin
                if (i_in_last) begin
                    r_phase  <= ESC_IDLE;
                    r_nibble <= 4'h0;
                    r_count  <= 17'd0;
                    r_err    <= ST_OK;
                end else begin
                    r_phase  <= n_phase;
                    r_nibble <= n_nibble;
                    r_count  <= n_count;
                    r_err    <= n_err;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pdu_back.sv
// Back stage: UTF-8 well-formedness check over the emitted bytes and the
// final status of each string. Depends on pdu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdu_back
    import pdu_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_fire,
    input  t_item i_item,
    output t_item o_item
);

    logic [1:0]  r_remain, n_remain;
    logic [1:0]  r_total, n_total;
    logic [20:0] r_acc, n_acc;
    logic        r_bad, n_bad;
    logic [7:0]  b;

    assign b = i_item.data;

    // UTF-8 sequence tracking
    always_comb begin
        n_remain = r_remain;
        n_total  = r_total;
        n_acc    = r_acc;
        n_bad    = r_bad;
        if (i_item.valid) begin
            if (r_remain == 2'd0) begin
                if (b <= UTF8_ASCII_MAX) begin
                    n_bad = r_bad;
                end else if (b >= UTF8_LEAD2_MIN && b <= UTF8_LEAD2_MAX) begin
                    n_remain = 2'd1;
                    n_total  = 2'd1;
                    n_acc    = {16'd0, b[4:0]};
                end else if (b >= UTF8_LEAD3_MIN && b <= UTF8_LEAD3_MAX) begin
                    n_remain = 2'd2;
                    n_total  = 2'd2;
                    n_acc    = {17'd0, b[3:0]};
                end else if (b >= UTF8_LEAD4_MIN && b <= UTF8_LEAD4_MAX) begin
                    n_remain = 2'd3;
                    n_total  = 2'd3;
                    n_acc    = {18'd0, b[2:0]};
                end else begin
                    n_bad = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                // expected a continuation byte
                n_bad    = 1'b1;
                n_remain = 2'd0;
            end else begin
                n_acc    = {r_acc[14:0], b[5:0]};
                n_remain = r_remain - 2'd1;
                // sequence complete: overlong, surrogate and range checks
                if (n_remain == 2'd0) begin
                    if ((r_total == 2'd2 && n_acc < CP_MIN_3BYTE) ||
                        (r_total == 2'd3 && n_acc < CP_MIN_4BYTE) ||
                        (n_acc >= CP_SURR_LO && n_acc <= CP_SURR_HI) ||
                        (n_acc > CP_MAX)) begin
                        n_bad = 1'b1;
                    end
                end
            end
        end
    end

    // Result item; the front status wins over a UTF-8 fault
    always_comb begin
        o_item = i_item;
        if (i_item.last && i_item.status == ST_OK && (n_bad || n_remain != 2'd0)) begin
            o_item.status = ST_BAD_UTF8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remain <= 2'd0;
            r_total  <= 2'd0;
            r_acc    <= 21'd0;
            r_bad    <= 1'b0;
        end else if (i_fire) begin
            if (i_item.last) begin
                r_remain <= 2'd0;
                r_total  <= 2'd0;
                r_acc    <= 21'd0;
                r_bad    <= 1'b0;
            end else begin
                r_remain <= n_remain;
                r_total  <= n_total;
                r_acc    <= n_acc;
                r_bad    <= n_bad;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/percent_decode_utf8_check_unit.sv
// Top level of the percent decoder with UTF-8 check.
// Depends on pdu_pkg, pdu_fifo, pdu_front and pdu_back.
//
// Usage:
//   Input side is a queue write port: drive i_in_byte / i_in_last and raise
//   push; a transfer happens on a clock edge with push high and full low.
//   Results come out of a queue read port: while empty is low the oldest
//   result sits on o_out_valid / o_out_byte / o_done_res / o_status, and a
//   transfer happens on a clock edge with pop high and empty low.
//   Every input byte gives exactly one result; o_status is meaningful on the
//   result with o_done_res set.
//   An accepted byte passes the middle queue and the UTF-8 checker before it can be popped.
//   Throughput: one byte per cycle while full is low; the front decoder handles a
//   byte per cycle and the UTF-8 checker drains one entry of the two-entry middle
//   queue per cycle into the two-entry result queue while that queue is not full.
//   If the receiver stops popping, the result queue fills, then the middle
//   queue, and full rises; up to four results are held without loss.
//   Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) takes effect at once;
//   write only while no string is in flight.
//   Synchronous reset empties both queues, clears the string state and sets
//   plus-as-space on and the length limit to 16384.
`timescale 1ns / 1ps
`default_nettype none

module percent_decode_utf8_check_unit
    import pdu_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [15:0] i_cfg_data,
    input  wire         push,
    output logic        full,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_in_last,
    output logic        empty,
    input  wire         pop,
    output logic        o_out_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_done_res,
    output logic [2:0]  o_status
);

    t_item front_item;
    t_item mid_item;
    t_item back_item;
    t_item out_item;
    logic  in_fire;
    logic  mid_full;
    logic  mid_empty;
    logic  out_full;
    logic  back_fire;

    assign full      = mid_full;
    assign in_fire   = push && !mid_full;
    assign back_fire = !mid_empty && !out_full;

    // Front: decode and classify
    pdu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (in_fire),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_item     (front_item)
    );

    // Queue between front and back
    pdu_fifo u_mid_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (front_item),
        .o_full    (mid_full),
        .i_pop     (back_fire),
        .o_rd_data (mid_item),
        .o_empty   (mid_empty)
    );

    // Back: UTF-8 check and final status
    pdu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (back_fire),
        .i_item  (mid_item),
        .o_item  (back_item)
    );

    // Result queue
    pdu_fifo u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (back_fire),
        .i_wr_data (back_item),
        .o_full    (out_full),
        .i_pop     (pop),
        .o_rd_data (out_item),
        .o_empty   (empty)
    );

    assign o_out_valid = out_item.valid;
    assign o_out_byte  = out_item.data;
    assign o_done_res  = out_item.last;
    assign o_status    = out_item.status;

    // A status other than ok only travels with the closing byte
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_done_res |-> o_status == ST_OK)
        else $error("status set on a result that is not the last of a string");

    // Dropped bytes carry zero data
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_out_valid |-> o_out_byte == 8'h00)
        else $error("data present on a result without a decoded byte");

    // An accepted byte lands in the middle queue
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> !mid_empty)
        else $error("accepted byte missing from the middle queue");

endmodule

`default_nettype wire

FILE: bench/tb_percent_decode_utf8_check_unit.sv
// Self-checking bench for percent_decode_utf8_check_unit: random and directed
// encoded strings, checked against an in-bench decoder. Depends on pdu_pkg.
`timescale 1ns / 1ps

module tb_percent_decode_utf8_check_unit;
    import pdu_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int RAND_PER_PHASE = 378;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_esc;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } t_enc_item;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        t_status    status;
    } t_decoded;

    typedef logic [7:0] t_byte_q[$];

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [15:0] cfg_data = 16'd0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  in_byte = 8'd0;
    logic        in_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        done_res;
    logic [2:0]  status;

    // bytes waiting to be sent, and decoder results still owed by the block
    t_enc_item encoded_pending[$];
    t_decoded  results_due[$];
    t_enc_item next_item;
    t_decoded  want;
    int        fails = 0;
    int        bytes_queued = 0;
    int        cyc = 0;
    int        stuck = 0;

    // decoder copy: configuration and per-string state
    logic        plus_space = 1'b1;
    logic [15:0] max_len = MAX_LEN_RESET;
    t_esc        esc_phase = ESC_NONE;
    logic [3:0]  hi_nib = 4'd0;
    logic [1:0]  u_left = 2'd0;
    logic [1:0]  u_len = 2'd0;
    logic [20:0] cp_acc = 21'd0;
    logic [16:0] enc_count = 17'd0;
    t_status     str_err = ST_OK;
    logic        u_bad = 1'b0;

    percent_decode_utf8_check_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .push        (push),
        .full        (full),
        .i_in_byte   (in_byte),
        .i_in_last   (in_last),
        .empty       (empty),
        .pop         (pop),
        .o_out_valid (out_valid),
        .o_out_byte  (out_byte),
        .o_done_res  (done_res),
        .o_status    (status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // 5-bit digit value, bit 4 set for a non-hex byte
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return 5'(c[3:0] + 4'd9);
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n - 4'd10);
    endfunction

    // track one decoded byte through the UTF-8 sequence checker
    function automatic void utf8_track(input logic [7:0] b);
        if (u_left == 2'd0) begin
            if (b <= 8'h7F) begin
                return;
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
                u_left = 2'd1; u_len = 2'd1; cp_acc = 21'(b[4:0]);
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                u_left = 2'd2; u_len = 2'd2; cp_acc = 21'(b[3:0]);
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                u_left = 2'd3; u_len = 2'd3; cp_acc = 21'(b[2:0]);
            end else begin
                u_bad = 1'b1;
            end
            return;
        end
        if (b[7:6] != 2'b10) begin
            u_bad = 1'b1;
            u_left = 2'd0;
            return;
        end
        cp_acc = {cp_acc[14:0], b[5:0]};
        u_left = u_left - 2'd1;
        if (u_left == 2'd0) begin
            if ((u_len == 2'd2 && cp_acc < 21'h800) ||
                (u_len == 2'd3 && cp_acc < 21'h10000) ||
                (cp_acc >= 21'hD800 && cp_acc <= 21'hDFFF) ||
                cp_acc > 21'h10FFFF) begin
                u_bad = 1'b1;
            end
        end
    endfunction

    // expected result for one accepted encoded byte
    function automatic t_decoded decode_encoded_byte(input logic [7:0] b, input logic last);
        t_decoded   r;
        logic       have;
        logic [7:0] val;
        logic       too_long;
        logic [4:0] d;
        have = 1'b0;
        val = 8'd0;
        r = '0;
        if (enc_count != COUNT_MAX) enc_count = enc_count + 17'd1;
        too_long = enc_count > {1'b0, max_len};
        case (esc_phase)
            ESC_NONE: begin
                if (b == CHAR_PERCENT) begin
                    esc_phase = ESC_HIGH;
                end else begin
                    val = (b == CHAR_PLUS && plus_space) ? CHAR_SPACE : b;
                    have = 1'b1;
                end
            end
            ESC_HIGH: begin
                d = hex_nibble(b);
                if (d[4] && str_err == ST_OK) str_err = ST_BAD_PERCENT;
                hi_nib = d[3:0];
                esc_phase = ESC_LOW;
            end
            default: begin
                d = hex_nibble(b);
                if (d[4]) begin
                    if (str_err == ST_OK) str_err = ST_BAD_PERCENT;
                end else begin
                    val = {hi_nib, d[3:0]};
                    have = 1'b1;
                end
                esc_phase = ESC_NONE;
            end
        endcase
        // control bytes are dropped and flagged
        if (have && (val < 8'h20 || val == 8'h7F)) begin
            if (str_err == ST_OK) str_err = ST_CONTROL;
            have = 1'b0;
        end
        if (have && str_err == ST_OK && !too_long) begin
            r.valid = 1'b1;
            r.data = val;
            utf8_track(val);
        end
        if (last) begin
            if (esc_phase != ESC_NONE && str_err == ST_OK) str_err = ST_BAD_PERCENT;
            r.last = 1'b1;
            if (too_long) r.status = ST_TOO_LONG;
            else if (str_err != ST_OK) r.status = str_err;
            else if (u_bad || u_left != 2'd0) r.status = ST_BAD_UTF8;
            else r.status = ST_OK;
            esc_phase = ESC_NONE;
            hi_nib = 4'd0;
            u_left = 2'd0;
            u_len = 2'd0;
            cp_acc = 21'd0;
            enc_count = 17'd0;
            str_err = ST_OK;
            u_bad = 1'b0;
        end
        return r;
    endfunction

    // random gaps, except during a quiet stretch of each window
    function automatic logic take_break();
        if ((cyc % 3000) >= 2300) return 1'b0;
        return $urandom_range(99) < 34;
    endfunction

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // driver: record each transfer, then load the next byte or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                results_due.insert(results_due.size(),
                                   decode_encoded_byte(in_byte, in_last));
            end
            if (!push || !full) begin
                if (encoded_pending.size() != 0 && !take_break()) begin
                    next_item = encoded_pending.pop_front();
                    push <= 1'b1;
                    in_byte <= next_item.code;
                    in_last <= next_item.last;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each popped result with the oldest owed one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (results_due.size() == 0) begin
                    $error("result with none owed: valid %0b byte %02h done %0b status %0d",
                           out_valid, out_byte, done_res, status);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (out_valid !== want.valid) begin
                        $error("out_valid: expected %0b, got %0b", want.valid, out_valid);
                        fails++;
                    end
                    if (out_byte !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                        fails++;
                    end
                    if (done_res !== want.last) begin
                        $error("done_res: expected %0b, got %0b", want.last, done_res);
                        fails++;
                    end
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fails++;
                    end
                end
            end
            pop <= !take_break();
        end
    end

    // watchdog on cycles with work outstanding but no transfer
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) ||
            (encoded_pending.size() == 0 && results_due.size() == 0)) begin
            stuck <= 0;
        end else if (stuck >= STUCK_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    task automatic send_string(input t_byte_q s);
        t_enc_item it;
        foreach (s[k]) begin
            it.code = s[k];
            it.last = (k == s.size() - 1);
            encoded_pending.insert(encoded_pending.size(), it);
        end
        bytes_queued += s.size();
    endtask

    // mostly well-formed strings, some broken, some pure noise
    task automatic queue_random_string();
        logic [7:0]  dec[$];
        logic [7:0]  enc[$];
        logic [20:0] cp;
        int          pos;
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 6)) enc.insert(enc.size(), 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 5)) begin
                case ($urandom_range(3))
                    0: dec.insert(dec.size(), 8'($urandom_range(8'h20, 8'h7E)));
                    1: begin
                        cp = 21'($urandom_range(21'h80, 21'h7FF));
                        dec.insert(dec.size(), {3'b110, cp[10:6]});
                        dec.insert(dec.size(), {2'b10, cp[5:0]});
                    end
                    2: begin
                        cp = 21'($urandom_range(21'h800, 21'hFFFF));
                        dec.insert(dec.size(), {4'b1110, cp[15:12]});
                        dec.insert(dec.size(), {2'b10, cp[11:6]});
                        dec.insert(dec.size(), {2'b10, cp[5:0]});
                    end
                    default: begin
                        cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
                        dec.insert(dec.size(), {5'b11110, cp[20:18]});
                        dec.insert(dec.size(), {2'b10, cp[17:12]});
                        dec.insert(dec.size(), {2'b10, cp[11:6]});
                        dec.insert(dec.size(), {2'b10, cp[5:0]});
                    end
                endcase
            end
            foreach (dec[k]) begin
                if (dec[k] == CHAR_PERCENT || dec[k][7] || $urandom_range(3) == 0) begin
                    enc.insert(enc.size(), CHAR_PERCENT);
                    enc.insert(enc.size(), hex_char(dec[k][7:4]));
                    enc.insert(enc.size(), hex_char(dec[k][3:0]));
                end else begin
                    enc.insert(enc.size(), dec[k]);
                end
            end
            // corrupt or drop one byte now and then
            if ($urandom_range(4) == 0) begin
                pos = $urandom_range(enc.size() - 1);
                if ($urandom_range(1) || enc.size() == 1) enc[pos] = 8'($urandom_range(255));
                else enc.delete(pos);
            end
        end
        send_string(enc);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == CFG_PLUS_SPACE) plus_space = val[0];
        else max_len = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (encoded_pending.size() != 0 || push || results_due.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    // stimulus and verdict
    initial begin
        int target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: plus as space, escapes, each error kind but too long
        send_string('{8'h2B, 8'h25, 8'h63, 8'h33, 8'hA9});  // "+%c3" then raw continuation
        send_string('{8'h25, 8'h47, 8'h30, 8'h41});         // bad hex digit
        send_string('{8'h00, 8'h7F});                       // control bytes
        send_string('{8'hE0, 8'h80, 8'h80});                // overlong
        send_string('{8'hED, 8'hA0, 8'h80});                // surrogate
        send_string('{8'hF4, 8'h90, 8'h80, 8'h80});         // above U+10FFFF
        send_string('{8'h25, 8'h46});                       // escape cut short
        send_string('{8'hFF});                              // byte that cannot lead
        send_string('{8'hC2});                              // sequence left open

        // literal plus, a limit of one, then a zero limit
        wait_drained();
        write_reg(CFG_PLUS_SPACE, 16'd0);
        write_reg(CFG_MAX_LEN, 16'd1);
        send_string('{8'h2B, 8'h62});
        send_string('{8'h25, 8'h34, 8'h31});
        wait_drained();
        write_reg(CFG_MAX_LEN, 16'd0);
        send_string('{8'h61});

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_reg(CFG_PLUS_SPACE, 16'd1);
                    write_reg(CFG_MAX_LEN, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_PLUS_SPACE, 16'd0);
                    write_reg(CFG_MAX_LEN, 16'($urandom_range(2, 30)));
                end
                2: begin
                    write_reg(CFG_PLUS_SPACE, 16'd1);
                    write_reg(CFG_MAX_LEN, 16'($urandom_range(2, 30)));
                end
                default: begin
                    write_reg(CFG_PLUS_SPACE, 16'($urandom_range(1)));
                    write_reg(CFG_MAX_LEN, MAX_LEN_RESET);
                end
            endcase
            target = bytes_queued + RAND_PER_PHASE;
            while (bytes_queued < target) queue_random_string();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fails == 0 && results_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
